### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QMCM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QMCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/qmcm_pkg.sv
// ---------------------------------------------------------------------------
// qmcm_pkg
// Shared constants, types and step functions of the quad mesh cell metrics.
// ---------------------------------------------------------------------------
package qmcm_pkg;

    localparam int QMCM_COORD_FRAC_BITS = 16;
    localparam int COORD_W     = 32;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 31;
    // face unit register levels: 5 prep, sqrt, divide, output
    localparam int FACE_LAT    = 6 + SQRT_STAGES + DIV_STAGES;

    localparam logic [30:0] SAT31   = 31'h7FFF_FFFF;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_state_t;

    typedef struct packed {
        logic [32:0] rem;
        logic [30:0] quo;
    } div_state_t;

    typedef struct packed {
        logic on;
        logic zero;
        logic big;
        logic sgn_x;
        logic sgn_y;
    } face_ctl_t;

    typedef struct packed {
        logic [30:0] len;
        logic [31:0] nrm_x;
        logic [31:0] nrm_y;
    } face_res_t;

    // one root bit per call, radicand consumed from the top two bits
    function automatic sqrt_state_t sqrt_step(input sqrt_state_t s);
        sqrt_state_t o;
        logic [35:0] acc;
        logic [35:0] trial;
        acc   = {s.rem, s.rad[63:62]};
        trial = {2'b00, s.root, 2'b01};
        o.rad = {s.rad[61:0], 2'b00};
        if (acc >= trial)
        begin
            o.rem  = 34'(acc - trial);
            o.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            o.rem  = acc[33:0];
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

    // one quotient bit per call, restoring
    function automatic div_state_t div_step(input div_state_t s, input logic [31:0] den);
        div_state_t  o;
        logic [32:0] d33;
        logic [32:0] r;
        logic        ge;
        d33   = {1'b0, den};
        ge    = (s.rem >= d33);
        r     = ge ? (s.rem - d33) : s.rem;
        o.quo = {s.quo[29:0], ge};
        o.rem = {r[31:0], 1'b0};
        return o;
    endfunction

endpackage

### hw/rtl/qmcm_face_unit.sv
// ---------------------------------------------------------------------------
// qmcm_face_unit
// Length and unit normal of one face: normalize, two pipelined square
// roots, two pipelined dividers. FACE_LAT register levels, advances on en.
// ---------------------------------------------------------------------------
module qmcm_face_unit
    import qmcm_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic               face_on,
    input  logic signed [32:0] dx,
    input  logic signed [32:0] dy,
    output face_res_t          res
);

    localparam int CTL_DEPTH = FACE_LAT - 2;

    // level 1
    logic [31:0] ax_reg, ay_reg;
    logic        sgx_reg, sgy_reg, on1_reg;
    // level 2
    face_ctl_t   ctl_next;
    face_ctl_t   ctl_reg [CTL_DEPTH];
    logic [31:0] ax2_reg, ay2_reg;
    logic [4:0]  sh_next, sh_reg;
    logic [61:0] sqa_reg, sqb_reg;
    // level 3..5
    logic [30:0] nx3_reg, ny3_reg, nx4_reg, ny4_reg, nx5_reg, ny5_reg;
    logic [63:0] suml3_reg, suml4_reg, suml5_reg, sumn5_reg;
    logic [61:0] nsqa4_reg, nsqb4_reg;
    // square roots
    sqrt_state_t sql_reg [SQRT_STAGES];
    sqrt_state_t sqn_reg [SQRT_STAGES];
    logic [30:0] nxs_reg [SQRT_STAGES];
    logic [30:0] nys_reg [SQRT_STAGES];
    // dividers
    div_state_t  dvx_reg [DIV_STAGES];
    div_state_t  dvy_reg [DIV_STAGES];
    logic [31:0] den_reg [DIV_STAGES];
    logic [31:0] rl_reg  [DIV_STAGES];
    // output
    face_res_t   res_next, res_reg;

    logic [31:0] or_v;
    logic [30:0] qxc, qyc;
    face_ctl_t   c_last;

    always_comb
    begin
        or_v             = ax_reg | ay_reg;
        ctl_next.on      = on1_reg;
        ctl_next.zero    = (or_v == 32'd0);
        ctl_next.big     = or_v[31];
        ctl_next.sgn_x   = sgx_reg;
        ctl_next.sgn_y   = sgy_reg;
        // shift that brings the leading one to bit 30
        sh_next = 5'd0;
        for (int i = 0; i < 31; i++)
        begin
            if (or_v[i])
                sh_next = 5'(30 - i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg  <= dx[32] ? 32'(-dx) : 32'(dx);
            ay_reg  <= dy[32] ? 32'(-dy) : 32'(dy);
            sgx_reg <= dx[32];
            sgy_reg <= dy[32];
            on1_reg <= face_on;

            ctl_reg[0] <= ctl_next;
            for (int k = 1; k < CTL_DEPTH; k++)
                ctl_reg[k] <= ctl_reg[k-1];
            ax2_reg <= ax_reg;
            ay2_reg <= ay_reg;
            sh_reg  <= sh_next;
            sqa_reg <= ax_reg[30:0] * ax_reg[30:0];
            sqb_reg <= ay_reg[30:0] * ay_reg[30:0];

            nx3_reg   <= ctl_reg[0].big ? ax2_reg[31:1] : 31'(ax2_reg[30:0] << sh_reg);
            ny3_reg   <= ctl_reg[0].big ? ay2_reg[31:1] : 31'(ay2_reg[30:0] << sh_reg);
            suml3_reg <= 64'(sqa_reg) + 64'(sqb_reg);

            nsqa4_reg <= nx3_reg * nx3_reg;
            nsqb4_reg <= ny3_reg * ny3_reg;
            nx4_reg   <= nx3_reg;
            ny4_reg   <= ny3_reg;
            suml4_reg <= suml3_reg;

            sumn5_reg <= 64'(nsqa4_reg) + 64'(nsqb4_reg);
            suml5_reg <= suml4_reg;
            nx5_reg   <= nx4_reg;
            ny5_reg   <= ny4_reg;

            sql_reg[0] <= sqrt_step('{rad: suml5_reg, rem: 34'd0, root: 32'd0});
            sqn_reg[0] <= sqrt_step('{rad: sumn5_reg, rem: 34'd0, root: 32'd0});
            nxs_reg[0] <= nx5_reg;
            nys_reg[0] <= ny5_reg;
            for (int k = 1; k < SQRT_STAGES; k++)
            begin
                sql_reg[k] <= sqrt_step(sql_reg[k-1]);
                sqn_reg[k] <= sqrt_step(sqn_reg[k-1]);
                nxs_reg[k] <= nxs_reg[k-1];
                nys_reg[k] <= nys_reg[k-1];
            end

            dvx_reg[0] <= div_step('{rem: 33'(nxs_reg[SQRT_STAGES-1]), quo: 31'd0},
                                   sqn_reg[SQRT_STAGES-1].root);
            dvy_reg[0] <= div_step('{rem: 33'(nys_reg[SQRT_STAGES-1]), quo: 31'd0},
                                   sqn_reg[SQRT_STAGES-1].root);
            den_reg[0] <= sqn_reg[SQRT_STAGES-1].root;
            rl_reg[0]  <= sql_reg[SQRT_STAGES-1].root;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                dvx_reg[k] <= div_step(dvx_reg[k-1], den_reg[k-1]);
                dvy_reg[k] <= div_step(dvy_reg[k-1], den_reg[k-1]);
                den_reg[k] <= den_reg[k-1];
                rl_reg[k]  <= rl_reg[k-1];
            end

            res_reg <= res_next;
        end
    end

    always_comb
    begin
        c_last = ctl_reg[CTL_DEPTH-1];
        qxc = (dvx_reg[DIV_STAGES-1].quo > ONE_Q30) ? ONE_Q30 : dvx_reg[DIV_STAGES-1].quo;
        qyc = (dvy_reg[DIV_STAGES-1].quo > ONE_Q30) ? ONE_Q30 : dvy_reg[DIV_STAGES-1].quo;
        if (!c_last.on || c_last.zero)
        begin
            res_next = '0;
        end
        else
        begin
            res_next.len   = (c_last.big || rl_reg[DIV_STAGES-1][31]) ?
                             SAT31 : rl_reg[DIV_STAGES-1][30:0];
            res_next.nrm_x = c_last.sgn_y ? (32'd0 - 32'(qyc)) : 32'(qyc);
            res_next.nrm_y = c_last.sgn_x ? 32'(qxc) : (32'd0 - 32'(qxc));
        end
    end

    assign res = res_reg;

endmodule

### hw/rtl/quad_mesh_cell_metrics_unit.sv
// ---------------------------------------------------------------------------
// quad_mesh_cell_metrics_unit
// Area, centroid and face normals of one structured quad grid cell.
// ---------------------------------------------------------------------------
// Input items come on the s_ stream: four corner points (P1 here, P2 +i,
// P3 diagonal, P4 +j) as signed fixed point, face flags in s_tuser.
// Each item gives one result item on the m_ stream: cell area and centroid
// (zero unless both faces exist), then length and Q2.30 unit normal of the
// +i face and of the +j face (zero for an absent or zero-length face).
// One item per cycle is sustained while the receiver takes results.
// The latency is set by the face path: 32 stages of square root (one root
// bit each) followed by 31 stages of division (one quotient bit each).
// The area uses 16x16 partial products summed in the next stage.
// The whole pipeline advances whenever the output register is empty or
// taken; when the receiver stalls with a result waiting, every stage holds
// and s_tready drops. Reset clears all valid bits; no clearing pass.
// ---------------------------------------------------------------------------
module quad_mesh_cell_metrics_unit
    import qmcm_pkg::*;
#(
    parameter int COORD_FRAC_BITS = QMCM_COORD_FRAC_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // x_here, y_here, x_next_i, y_next_i, x_diag, y_diag, x_next_j, y_next_j
    input  logic [255:0] s_tdata,
    // has_i_face, has_j_face
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // cell_area, centroid_x, centroid_y, i_face_length, i_face_normal_x,
    // i_face_normal_y, j_face_length, j_face_normal_x, j_face_normal_y, 3 pad
    output logic [287:0] m_tdata
);

    localparam int PIPE_DEPTH = FACE_LAT + 1;
    localparam int CELL_DEPTH = PIPE_DEPTH - 5;

    typedef struct packed {
        logic [30:0] area;
        logic [31:0] cx;
        logic [31:0] cy;
    } cell_res_t;

    logic adv;
    logic vld_reg [PIPE_DEPTH];

    logic signed [31:0] x1, y1, x2, y2, x3, y3, x4, y4;

    // stage 1
    logic signed [32:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [32:0] dxi_reg, dyi_reg, dxj_reg, dyj_reg;
    logic signed [33:0] sx_reg, sy_reg;
    logic               fi_reg, fj_reg;
    // stage 2
    logic [31:0] am_reg, bm_reg, cm_reg, dm_reg;
    logic        sp2_reg, sq2_reg;
    logic [31:0] cx2_reg, cy2_reg, cx3_reg, cy3_reg, cx4_reg, cy4_reg, cx5_reg, cy5_reg;
    logic        cell2_reg, cell3_reg, cell4_reg, cell5_reg;
    // stage 3
    logic [31:0] p_ll_reg, p_lh_reg, p_hl_reg, p_hh_reg;
    logic [31:0] q_ll_reg, q_lh_reg, q_hl_reg, q_hh_reg;
    logic        sp3_reg, sq3_reg, sp4_reg, sq4_reg;
    // stage 4
    logic [63:0] p_reg, q_reg;
    // stage 5
    logic [64:0] mag_reg;
    // stage 6 on
    logic [64:0] ash;
    cell_res_t   cell_next;
    cell_res_t   cell_reg [CELL_DEPTH];

    face_res_t   ires, jres;

    assign adv      = !vld_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[PIPE_DEPTH-1];

    assign x1 = signed'(s_tdata[31:0]);
    assign y1 = signed'(s_tdata[63:32]);
    assign x2 = signed'(s_tdata[95:64]);
    assign y2 = signed'(s_tdata[127:96]);
    assign x3 = signed'(s_tdata[159:128]);
    assign y3 = signed'(s_tdata[191:160]);
    assign x4 = signed'(s_tdata[223:192]);
    assign y4 = signed'(s_tdata[255:224]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_DEPTH; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < PIPE_DEPTH; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg   <= 33'(x1) - 33'(x3);
            b_reg   <= 33'(y2) - 33'(y4);
            c_reg   <= 33'(x2) - 33'(x4);
            d_reg   <= 33'(y1) - 33'(y3);
            dxi_reg <= 33'(x2) - 33'(x1);
            dyi_reg <= 33'(y2) - 33'(y1);
            dxj_reg <= 33'(x4) - 33'(x1);
            dyj_reg <= 33'(y4) - 33'(y1);
            sx_reg  <= 34'(x1) + 34'(x2) + 34'(x3) + 34'(x4);
            sy_reg  <= 34'(y1) + 34'(y2) + 34'(y3) + 34'(y4);
            fi_reg  <= s_tuser[0];
            fj_reg  <= s_tuser[1];

            am_reg    <= a_reg[32] ? 32'(-a_reg) : 32'(a_reg);
            bm_reg    <= b_reg[32] ? 32'(-b_reg) : 32'(b_reg);
            cm_reg    <= c_reg[32] ? 32'(-c_reg) : 32'(c_reg);
            dm_reg    <= d_reg[32] ? 32'(-d_reg) : 32'(d_reg);
            sp2_reg   <= a_reg[32] ^ b_reg[32];
            sq2_reg   <= c_reg[32] ^ d_reg[32];
            // floor of sum/4
            cx2_reg   <= sx_reg[33:2];
            cy2_reg   <= sy_reg[33:2];
            cell2_reg <= fi_reg && fj_reg;

            p_ll_reg <= am_reg[15:0]  * bm_reg[15:0];
            p_lh_reg <= am_reg[15:0]  * bm_reg[31:16];
            p_hl_reg <= am_reg[31:16] * bm_reg[15:0];
            p_hh_reg <= am_reg[31:16] * bm_reg[31:16];
            q_ll_reg <= cm_reg[15:0]  * dm_reg[15:0];
            q_lh_reg <= cm_reg[15:0]  * dm_reg[31:16];
            q_hl_reg <= cm_reg[31:16] * dm_reg[15:0];
            q_hh_reg <= cm_reg[31:16] * dm_reg[31:16];
            sp3_reg  <= sp2_reg;
            sq3_reg  <= sq2_reg;
            cx3_reg  <= cx2_reg;
            cy3_reg  <= cy2_reg;
            cell3_reg <= cell2_reg;

            p_reg <= {p_hh_reg, 32'd0} + (64'(33'(p_lh_reg) + 33'(p_hl_reg)) << 16)
                     + 64'(p_ll_reg);
            q_reg <= {q_hh_reg, 32'd0} + (64'(33'(q_lh_reg) + 33'(q_hl_reg)) << 16)
                     + 64'(q_ll_reg);
            sp4_reg   <= sp3_reg;
            sq4_reg   <= sq3_reg;
            cx4_reg   <= cx3_reg;
            cy4_reg   <= cy3_reg;
            cell4_reg <= cell3_reg;

            if (sp4_reg == sq4_reg)
                mag_reg <= (p_reg >= q_reg) ? 65'(p_reg - q_reg) : 65'(q_reg - p_reg);
            else
                mag_reg <= 65'(p_reg) + 65'(q_reg);
            cx5_reg   <= cx4_reg;
            cy5_reg   <= cy4_reg;
            cell5_reg <= cell4_reg;

            cell_reg[0] <= cell_next;
            for (int k = 1; k < CELL_DEPTH; k++)
                cell_reg[k] <= cell_reg[k-1];
        end
    end

    always_comb
    begin
        ash = mag_reg >> (COORD_FRAC_BITS + 1);
        if (cell5_reg)
        begin
            cell_next.area = (|ash[64:31]) ? SAT31 : ash[30:0];
            cell_next.cx   = cx5_reg;
            cell_next.cy   = cy5_reg;
        end
        else
        begin
            cell_next = '0;
        end
    end

    qmcm_face_unit u_face_i
    (
        .clk     (clk),
        .en      (adv),
        .face_on (fi_reg),
        .dx      (dxi_reg),
        .dy      (dyi_reg),
        .res     (ires)
    );

    qmcm_face_unit u_face_j
    (
        .clk     (clk),
        .en      (adv),
        .face_on (fj_reg),
        .dx      (dxj_reg),
        .dy      (dyj_reg),
        .res     (jres)
    );

    assign m_tdata = {3'b000,
                      jres.nrm_y, jres.nrm_x, jres.len,
                      ires.nrm_y, ires.nrm_x, ires.len,
                      cell_reg[CELL_DEPTH-1].cy, cell_reg[CELL_DEPTH-1].cx,
                      cell_reg[CELL_DEPTH-1].area};

endmodule

### hw/rtl/qmcm_checker.sv
// ---------------------------------------------------------------------------
// qmcm_checker
// Port-level checks of the quad mesh cell metrics unit, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qmcm_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [287:0] m_tdata
);

    `QMCM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output item dropped")
    `QMCM_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "output item changed")
    // a held result freezes the whole pipeline, input included
    `QMCM_ASSERT_IMPL(a_stall_in, m_tvalid && !m_tready, !s_tready, "input taken during stall")
    // a nonzero i face length always comes with a nonzero normal
    `QMCM_ASSERT_IMPL(a_i_normal, m_tvalid && (m_tdata[125:95] != 31'd0),
        (m_tdata[157:126] != 32'd0) || (m_tdata[189:158] != 32'd0), "i face normal zero")

endmodule

bind quad_mesh_cell_metrics_unit qmcm_checker u_qmcm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/quad_mesh_cell_metrics_unit_tb.sv
// ---------------------------------------------------------------------------
// quad_mesh_cell_metrics_unit_tb
// Self-checking bench for the quad mesh cell metrics unit.
// ---------------------------------------------------------------------------
// Drives corner points and face flags on the input stream and predicts the
// cell area, centroid and face length/normal of every item in fixed point.
// Results are checked in order against the predictions. Both streams get
// random gaps; one phase holds off the output long enough to stall the input.
// ---------------------------------------------------------------------------
module quad_mesh_cell_metrics_unit_tb
    import qmcm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC      = QMCM_COORD_FRAC_BITS;
    localparam int IDLE_LIM  = 5000;
    localparam int DRAIN_GAP = 100;
    localparam int LONG_HOLD = 400;

    typedef struct {
        logic [31:0] x [4];
        logic [31:0] y [4];
        logic        has_i;
        logic        has_j;
    } quad_in_t;

    typedef struct {
        logic [30:0] area;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [30:0] i_len;
        logic [31:0] i_nx;
        logic [31:0] i_ny;
        logic [30:0] j_len;
        logic [31:0] j_nx;
        logic [31:0] j_ny;
    } metrics_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [287:0] m_tdata;

    metrics_t pending_metrics[$];
    int       mismatches;
    int       hold_off;
    int       idle_cycles;
    // long hold-off request: the test bumps stall_req, the receiver follows with stall_ack
    int       stall_req;
    int       stall_ack;

    quad_mesh_cell_metrics_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] abs64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic void face_geometry(input longint dx, input longint dy,
                                          output logic [30:0] len,
                                          output logic [31:0] nx, output logic [31:0] ny);
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] m;
        logic [63:0] r;
        logic [63:0] qx;
        logic [63:0] qy;
        ax  = abs64(dx);
        ay  = abs64(dy);
        len = 0;
        nx  = 0;
        ny  = 0;
        if (ax == 0 && ay == 0)
            return;
        if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000)
            len = SAT31;
        else
        begin
            r   = int_sqrt(ax * ax + ay * ay);
            len = r > 64'(SAT31) ? SAT31 : r[30:0];
        end
        m = ax > ay ? ax : ay;
        if (m >= 64'h8000_0000)
        begin
            ax = ax >> 1;
            ay = ay >> 1;
        end
        else
            while (m < 64'(ONE_Q30))
            begin
                ax = ax << 1;
                ay = ay << 1;
                m  = m << 1;
            end
        r = int_sqrt(ax * ax + ay * ay);
        if (r == 0)
            return;
        qx = (ax << 30) / r;
        qy = (ay << 30) / r;
        if (qx > 64'(ONE_Q30))
            qx = 64'(ONE_Q30);
        if (qy > 64'(ONE_Q30))
            qy = 64'(ONE_Q30);
        nx = dy < 0 ? 32'(-qy) : qy[31:0];
        ny = dx < 0 ? qx[31:0] : 32'(-qx);
    endfunction

    function automatic metrics_t predict_metrics(input quad_in_t q);
        metrics_t    r;
        longint      xs [4];
        longint      ys [4];
        longint      a, b, c, d;
        logic [63:0] p, pq;
        logic [64:0] mag;
        logic [64:0] area;
        longint      sx, sy;
        for (int k = 0; k < 4; k++)
        begin
            xs[k] = longint'($signed(q.x[k]));
            ys[k] = longint'($signed(q.y[k]));
        end
        r = '{default: '0};
        if (q.has_i && q.has_j)
        begin
            a  = xs[0] - xs[2];
            b  = ys[1] - ys[3];
            c  = xs[1] - xs[3];
            d  = ys[0] - ys[2];
            p  = abs64(a) * abs64(b);
            pq = abs64(c) * abs64(d);
            // same sign of both terms: magnitudes subtract
            if (((a < 0) != (b < 0)) == ((c < 0) != (d < 0)))
                mag = p >= pq ? 65'(p - pq) : 65'(pq - p);
            else
                mag = 65'(p) + 65'(pq);
            area   = mag >> (FRAC + 1);
            r.area = area > 65'(SAT31) ? SAT31 : area[30:0];
            sx     = (xs[0] + xs[1] + xs[2] + xs[3]) >>> 2;
            sy     = (ys[0] + ys[1] + ys[2] + ys[3]) >>> 2;
            r.cx   = sx[31:0];
            r.cy   = sy[31:0];
        end
        if (q.has_i)
            face_geometry(xs[1] - xs[0], ys[1] - ys[0], r.i_len, r.i_nx, r.i_ny);
        if (q.has_j)
            face_geometry(xs[3] - xs[0], ys[3] - ys[0], r.j_len, r.j_nx, r.j_ny);
        return r;
    endfunction

    // ---------------- driving ----------------

    task automatic send_quad(input quad_in_t q);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {q.y[3], q.x[3], q.y[2], q.x[2], q.y[1], q.x[1], q.y[0], q.x[0]};
        s_tuser  <= {q.has_j, q.has_i};
        do
            @(posedge clk);
        while (!s_tready);
        pending_metrics.push_back(predict_metrics(q));
        case ($urandom_range(0, 19)) inside
            [0:11]:  gap = 0;
            19:      gap = $urandom_range(10, 40);
            default: gap = $urandom_range(1, 3);
        endcase
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic quad_in_t make_quad(input logic [31:0] xv [4], input logic [31:0] yv [4],
                                           input logic hi, input logic hj);
        quad_in_t q;
        q.x     = xv;
        q.y     = yv;
        q.has_i = hi;
        q.has_j = hj;
        return q;
    endfunction

    // random quad: either fully random corners or a small mesh-like cell
    function automatic quad_in_t random_quad();
        quad_in_t q;
        int       sh;
        logic [31:0] bx, by;
        q.has_i = ($urandom_range(0, 5) != 0);
        q.has_j = ($urandom_range(0, 5) != 0);
        if ($urandom_range(0, 3) == 0)
        begin
            for (int k = 0; k < 4; k++)
            begin
                q.x[k] = $urandom;
                q.y[k] = $urandom;
            end
        end
        else
        begin
            sh = $urandom_range(0, 29);
            bx = $urandom;
            by = $urandom;
            for (int k = 0; k < 4; k++)
            begin
                q.x[k] = bx + (32'($signed($urandom_range(0, 255)) - 128) << sh);
                q.y[k] = by + (32'($signed($urandom_range(0, 255)) - 128) << sh);
            end
            // occasional degenerate face
            if ($urandom_range(0, 15) == 0)
            begin
                q.x[1] = q.x[0];
                q.y[1] = q.y[0];
            end
            if ($urandom_range(0, 15) == 0)
            begin
                q.x[3] = q.x[0];
                q.y[3] = q.y[0];
            end
        end
        return q;
    endfunction

    // ---------------- checking ----------------

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        metrics_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_metrics.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result item with nothing expected");
            end
            else
            begin
                e = pending_metrics.pop_front();
                check_field("cell_area",       32'(e.area), 32'(m_tdata[30:0]));
                check_field("centroid_x",      e.cx,        m_tdata[62:31]);
                check_field("centroid_y",      e.cy,        m_tdata[94:63]);
                check_field("i_face_length",   32'(e.i_len), 32'(m_tdata[125:95]));
                check_field("i_face_normal_x", e.i_nx,      m_tdata[157:126]);
                check_field("i_face_normal_y", e.i_ny,      m_tdata[189:158]);
                check_field("j_face_length",   32'(e.j_len), 32'(m_tdata[220:190]));
                check_field("j_face_normal_x", e.j_nx,      m_tdata[252:221]);
                check_field("j_face_normal_y", e.j_ny,      m_tdata[284:253]);
            end
        end
    end

    // receiver: random stalls, or a forced hold-off while hold_off > 0
    always @(posedge clk)
    begin
        if (stall_req != stall_ack)
        begin
            stall_ack <= stall_req;
            hold_off  <= LONG_HOLD;
            m_tready  <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 8)
            m_tready <= 1'b0;
        else if ($urandom_range(0, 99) < 2)
            hold_off <= $urandom_range(10, 40);
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIM)
        begin
            $display("quad_mesh_cell_metrics_unit_tb: done, errors");
            $finish;
        end
    end

    // ---------------- tests ----------------

    task automatic test_directed();
        logic [31:0] mn, mx;
        logic [31:0] xv [4];
        logic [31:0] yv [4];
        mn = 32'h8000_0000;
        mx = 32'h7FFF_FFFF;
        xv = '{0, 0, 0, 0};  yv = '{0, 0, 0, 0};
        send_quad(make_quad(xv, yv, 1, 1));
        xv = '{mn, mn, mn, mn}; yv = '{mn, mn, mn, mn};
        send_quad(make_quad(xv, yv, 1, 1));
        xv = '{mx, mx, mx, mx}; yv = '{mx, mx, mx, mx};
        send_quad(make_quad(xv, yv, 1, 1));
        // largest area, saturates; faces longer than the length range
        xv = '{mn, mx, mx, mn}; yv = '{mn, mn, mx, mx};
        send_quad(make_quad(xv, yv, 1, 1));
        xv = '{mx, mn, mn, mx}; yv = '{mx, mx, mn, mn};
        send_quad(make_quad(xv, yv, 1, 1));
        // unit square, and flags off in turn
        xv = '{0, 32'h1_0000, 32'h1_0000, 0}; yv = '{0, 0, 32'h1_0000, 32'h1_0000};
        send_quad(make_quad(xv, yv, 1, 1));
        send_quad(make_quad(xv, yv, 0, 1));
        send_quad(make_quad(xv, yv, 1, 0));
        send_quad(make_quad(xv, yv, 0, 0));
        // negative centroid rounds toward minus infinity
        xv = '{-1, -1, -1, 0}; yv = '{-3, 0, 0, 0};
        send_quad(make_quad(xv, yv, 1, 1));
        // coincident points on each face
        xv = '{5, 5, 9, 5}; yv = '{7, 7, 1, 7};
        send_quad(make_quad(xv, yv, 1, 1));
        // axis-aligned faces of both signs, one tiny
        xv = '{0, -32'sd1, 3, 0}; yv = '{0, 0, 3, 32'sd1};
        send_quad(make_quad(xv, yv, 1, 1));
        xv = '{0, 0, 3, -32'sd77}; yv = '{0, -32'sd65536, 3, 0};
        send_quad(make_quad(xv, yv, 1, 1));
        // a diagonal face pair at exact 45 degrees, then faces between coordinate extremes
        xv = '{100, 200, 50, 0}; yv = '{100, 200, 50, 200};
        send_quad(make_quad(xv, yv, 1, 1));
        xv = '{mx, mn, 0, mn}; yv = '{0, 0, 0, mx};
        send_quad(make_quad(xv, yv, 1, 1));
        xv = '{mn, mx, 0, mn}; yv = '{mn, mn, 0, mx};
        send_quad(make_quad(xv, yv, 1, 1));
    endtask

    task automatic test_random(input int n);
        for (int k = 0; k < n; k++)
            send_quad(random_quad());
    endtask

    // output held off for a long stretch while input keeps offering
    task automatic test_backpressure();
        stall_req++;
        test_random(200);
    endtask

    // sender pauses until every result has come, then resumes
    task automatic test_drain_pause();
        test_random(50);
        s_tvalid <= 1'b0;
        while (pending_metrics.size() != 0)
            @(posedge clk);
        test_random(100);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        mismatches = 0;
        hold_off   = 0;
        stall_req  = 0;
        stall_ack  = 0;
        idle_cycles = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(600);
        test_backpressure();
        test_drain_pause();
        test_random(450);

        s_tvalid <= 1'b0;
        while (pending_metrics.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
        if (mismatches == 0)
            $display("quad_mesh_cell_metrics_unit_tb: done, clean");
        else
            $display("quad_mesh_cell_metrics_unit_tb: done, errors");
        $finish;
    end

endmodule

### quad_mesh_cell_metrics_unit.f
+incdir+hw/rtl
hw/rtl/qmcm_pkg.sv
hw/rtl/qmcm_face_unit.sv
hw/rtl/quad_mesh_cell_metrics_unit.sv
hw/rtl/qmcm_checker.sv
tb/quad_mesh_cell_metrics_unit_tb.sv
